// File: rtl/atsg_pkg.sv
// ----------------------------------------------------------------------------
// atsg_pkg: shared types and constants of the aperiodic tile sequence generator
// register indexes, symbol source modes and register reset values
// ----------------------------------------------------------------------------
`default_nettype none

package atsg_pkg;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_MODE   = 2'd0,
      CSR_SLOPE  = 2'd1,
      CSR_PHASE  = 2'd2,
      CSR_BUDGET = 2'd3
   } csr_index_type;

   // raw symbol sources
   typedef enum logic [1:0] {
      MODE_CUT_PROJECT     = 2'd0,
      MODE_THUE_MORSE      = 2'd1,
      MODE_RUDIN_SHAPIRO   = 2'd2,
      MODE_PERIOD_DOUBLING = 2'd3
   } mode_type;

   localparam int DATA_BITS = 32;

   // 2^32 divided by the golden ratio, truncated
   localparam logic [DATA_BITS-1:0] SLOPE_RESET  = 32'd2654435769;
   localparam logic [DATA_BITS-1:0] PHASE_RESET  = 32'd0;
   localparam logic [DATA_BITS-1:0] BUDGET_RESET = 32'd0;

   localparam logic [1:0] WORDS_SHORT = 2'd1;
   localparam logic [1:0] WORDS_LONG  = 2'd2;

endpackage : atsg_pkg

`default_nettype wire

// File: rtl/aperiodic_tile_sequence_generator_unit.sv
// ----------------------------------------------------------------------------
// aperiodic_tile_sequence_generator_unit: long/short tile stream generator
// result: the tile for an accepted request is registered and shows on rsp_ in the cycle after
// throughput: one request per cycle while the result register is empty or its tile is being taken
// reset: synchronous, restores register defaults and clears the run state
// ----------------------------------------------------------------------------
`default_nettype none

module aperiodic_tile_sequence_generator_unit #(
   parameter int COUNT_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_restart,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_tile_pos,
   output logic [1:0]       rsp_tile_words,
   output logic             rsp_is_long,
   output logic             rsp_last_tile,

   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);

   // configuration registers
   atsg_pkg::mode_type mode_ff;
   logic [31:0]        slope_ff;
   logic [31:0]        phase_ff;
   logic [31:0]        budget_ff;

   // run state
   logic [COUNT_BITS-1:0] index_ff, index_in;
   logic [31:0]           acc_ff, acc_in;
   logic [31:0]           done_ff, done_in;
   logic                  finished_ff, finished_in;
   logic                  held_valid_ff, held_valid_in;
   logic                  held_long_ff, held_long_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] pos_ff, pos_in;
   logic [1:0]  words_ff, words_in;
   logic        long_ff, long_in;
   logic        last_ff, last_in;

   logic req_fire;
   logic tile_emit;

   // raw symbol for index idx; succ is idx+1 (wrapped), carry is the
   // cut-and-project carry for that symbol
   function automatic logic raw_symbol(input atsg_pkg::mode_type m,
                                       input logic [COUNT_BITS-1:0] idx,
                                       input logic [COUNT_BITS-1:0] succ,
                                       input logic carry);
      logic [COUNT_BITS-1:0] iso;
      logic                  even_hit;
      logic                  sym;
      iso      = succ & (~succ + {{(COUNT_BITS-1){1'b0}}, 1'b1});
      even_hit = 1'b0;
      for (int i = 0; i < COUNT_BITS; i++) begin
         if ((i % 2) == 0) begin
            even_hit = even_hit | iso[i];
         end
      end
      case (m)
         atsg_pkg::MODE_CUT_PROJECT:   sym = carry;
         atsg_pkg::MODE_THUE_MORSE:    sym = ^idx;
         atsg_pkg::MODE_RUDIN_SHAPIRO: sym = ^(idx & (idx >> 1));
         default: begin
            // k+1 wrapped to zero counts as COUNT_BITS trailing zeros
            if (succ == '0) begin
               sym = ((COUNT_BITS % 2) == 0);
            end else begin
               sym = even_hit;
            end
         end
      endcase
      return sym;
   endfunction

   // phase sums for one and two slope steps, computed side by side
   logic [32:0] sum_one;
   logic [33:0] sum_two;
   logic        carry_one, carry_two;

   assign sum_one   = {1'b0, acc_ff} + {1'b0, slope_ff};
   assign sum_two   = {2'b0, acc_ff} + {1'b0, slope_ff, 1'b0};
   assign carry_one = sum_one[32];
   // the high bits of the double sum hold both carries added together
   assign carry_two = (sum_two[33:32] != {1'b0, carry_one});

   logic [COUNT_BITS-1:0] idx_p1, idx_p2;
   logic                  raw_k, raw_k1;

   assign idx_p1 = index_ff + {{(COUNT_BITS-1){1'b0}}, 1'b1};
   assign idx_p2 = index_ff + {{(COUNT_BITS-2){1'b0}}, 2'd2};
   assign raw_k  = raw_symbol(mode_ff, index_ff, idx_p1, carry_one);
   assign raw_k1 = raw_symbol(mode_ff, idx_p1, idx_p2, carry_two);

   // handshake: the result register frees up as its tile is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   logic [31:0] remaining;
   logic        rem_ge2, rem_ge3, ended;
   logic        first_long, second_sym, second_long, tile_long, tile_last;
   logic [1:0]  used;
   logic [1:0]  tile_words;

   always_comb begin
      remaining = budget_ff - done_ff;
      rem_ge2   = remaining > 32'd1;
      rem_ge3   = remaining > 32'd2;
      ended     = finished_ff || (done_ff >= budget_ff);

      // first symbol: the held lookahead, else symbol k
      if (held_valid_ff) begin
         first_long = held_long_ff && rem_ge2;
         second_sym = raw_k;
      end else begin
         first_long = raw_k && rem_ge2;
         second_sym = raw_k1;
      end

      // a short first symbol looks one symbol ahead to merge two shorts
      second_long = second_sym && rem_ge3;
      tile_long   = first_long || (rem_ge2 && !second_long);
      tile_words  = tile_long ? atsg_pkg::WORDS_LONG : atsg_pkg::WORDS_SHORT;
      tile_last   = {30'd0, tile_words} >= remaining;

      // symbols taken from the source this request
      used = {1'b0, !held_valid_ff} + {1'b0, !first_long && rem_ge2};

      tile_emit = req_fire && !req_restart && !ended;

      index_in      = index_ff;
      acc_in        = acc_ff;
      done_in       = done_ff;
      finished_in   = finished_ff;
      held_valid_in = held_valid_ff;
      held_long_in  = held_long_ff;

      if (req_fire && req_restart) begin
         index_in      = '0;
         acc_in        = phase_ff;
         done_in       = '0;
         finished_in   = 1'b0;
         held_valid_in = 1'b0;
         held_long_in  = 1'b0;
      end else if (req_fire && ended) begin
         finished_in   = 1'b1;
         held_valid_in = 1'b0;
      end else if (tile_emit) begin
         index_in = index_ff + {{(COUNT_BITS-2){1'b0}}, used};
         // phase only steps under cut-and-project
         if (mode_ff == atsg_pkg::MODE_CUT_PROJECT) begin
            case (used)
               2'd1:    acc_in = sum_one[31:0];
               2'd2:    acc_in = sum_two[31:0];
               default: acc_in = acc_ff;
            endcase
         end
         done_in = done_ff + {30'd0, tile_words};
         // a long lookahead symbol waits for the next request
         held_valid_in = !first_long && rem_ge2 && second_long && !tile_last;
         held_long_in  = held_valid_in;
         finished_in   = tile_last;
      end

      rsp_valid_in = tile_emit || (rsp_valid_ff && !rsp_ready);
      pos_in       = tile_emit ? done_ff    : pos_ff;
      words_in     = tile_emit ? tile_words : words_ff;
      long_in      = tile_emit ? tile_long  : long_ff;
      last_in      = tile_emit ? tile_last  : last_ff;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= atsg_pkg::MODE_CUT_PROJECT;
         slope_ff  <= atsg_pkg::SLOPE_RESET;
         phase_ff  <= atsg_pkg::PHASE_RESET;
         budget_ff <= atsg_pkg::BUDGET_RESET;
      end else if (csr_write_en) begin
         unique case (atsg_pkg::csr_index_type'(csr_index))
            atsg_pkg::CSR_MODE:   mode_ff   <= atsg_pkg::mode_type'(csr_write_data[1:0]);
            atsg_pkg::CSR_SLOPE:  slope_ff  <= csr_write_data;
            atsg_pkg::CSR_PHASE:  phase_ff  <= csr_write_data;
            atsg_pkg::CSR_BUDGET: budget_ff <= csr_write_data;
            default:              mode_ff   <= mode_ff;
         endcase
      end
   end

   // run state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff      <= '0;
         acc_ff        <= atsg_pkg::PHASE_RESET;
         done_ff       <= '0;
         finished_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         held_long_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         index_ff      <= index_in;
         acc_ff        <= acc_in;
         done_ff       <= done_in;
         finished_ff   <= finished_in;
         held_valid_ff <= held_valid_in;
         held_long_ff  <= held_long_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      words_ff <= words_in;
      long_ff  <= long_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tile_pos   = pos_ff;
   assign rsp_tile_words = words_ff;
   assign rsp_is_long    = long_ff;
   assign rsp_last_tile  = last_ff;

`ifndef NO_ASSERTIONS
   // a finished run never keeps a lookahead symbol
   a_finished_no_held: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !held_valid_ff)
      else $error("lookahead held after run finished");

   // tile width agrees with the long mark
   a_words_match_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_is_long && rsp_tile_words == atsg_pkg::WORDS_LONG) ||
                        (!rsp_is_long && rsp_tile_words == atsg_pkg::WORDS_SHORT)))
      else $error("tile words disagree with long mark");

   // a last tile ends the run
   a_last_sets_finished: assert property (@(posedge clock) disable iff (reset)
      (tile_emit && tile_last) |=> finished_ff)
      else $error("run not finished after last tile");

   // a restart clears the word count
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_restart) |=> (done_ff == '0 && !finished_ff && !rsp_valid_ff) ||
                                    (done_ff == '0 && !finished_ff))
      else $error("restart left run state behind");
`endif

endmodule : aperiodic_tile_sequence_generator_unit

`default_nettype wire

// File: bench/tile_stream_checker.sv
// ----------------------------------------------------------------------------
// tile_stream_checker: tile prediction and response comparison
// follows register writes and accepted requests, works out each tile the
// generator owes and compares every accepted response against the oldest one
// ----------------------------------------------------------------------------
`default_nettype none

module tile_stream_checker #(
   parameter int COUNT_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        req_restart,

   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [31:0] rsp_tile_pos,
   input  wire logic [1:0]  rsp_tile_words,
   input  wire logic        rsp_is_long,
   input  wire logic        rsp_last_tile,

   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data,

   output int               tiles_owed,
   output int               mismatches
);

   typedef struct packed {
      logic [31:0] pos;
      logic [1:0]  words;
      logic        is_long;
      logic        last;
   } tile_rec_type;

   tile_rec_type tiles_due[$];

   // register copies
   atsg_pkg::mode_type     src_mode;
   logic [31:0]            slope;
   logic [31:0]            phase_start;
   logic [31:0]            budget;

   // run state
   logic [COUNT_BITS-1:0]  sym_idx;
   logic [31:0]            phase_acc;
   logic [31:0]            words_done;
   logic                   run_over;
   logic                   held_valid;
   logic                   held_long;

   task automatic clear_run();
      sym_idx    = '0;
      phase_acc  = phase_start;
      words_done = '0;
      run_over   = 1'b0;
      held_valid = 1'b0;
      held_long  = 1'b0;
   endtask

   // next raw symbol, clipped to short when only one word is left
   function automatic logic draw_symbol(input logic [31:0] remaining);
      logic [32:0]           sum;
      logic [31:0]           k;
      logic [COUNT_BITS-1:0] k_next;
      int                    tz;
      logic                  lng;
      k = 32'(sym_idx);
      case (src_mode)
         atsg_pkg::MODE_CUT_PROJECT: begin
            sum       = {1'b0, phase_acc} + {1'b0, slope};
            phase_acc = sum[31:0];
            lng       = sum[32];
         end
         atsg_pkg::MODE_THUE_MORSE:    lng = ^k;
         atsg_pkg::MODE_RUDIN_SHAPIRO: lng = ^(k & (k >> 1));
         default: begin
            // trailing zeros of k+1, all of COUNT_BITS when it wraps to zero
            k_next = sym_idx + {{(COUNT_BITS-1){1'b0}}, 1'b1};
            tz     = 0;
            while (tz < COUNT_BITS && k_next[tz] == 1'b0) tz++;
            lng = (tz % 2 == 0);
         end
      endcase
      sym_idx = sym_idx + {{(COUNT_BITS-1){1'b0}}, 1'b1};
      if (remaining < 32'd2) lng = 1'b0;
      return lng;
   endfunction

   task automatic advance_tiling(input logic restart);
      logic [31:0]  remaining;
      logic         lng;
      tile_rec_type t;
      if (restart) begin
         clear_run();
         return;
      end
      if (run_over || words_done >= budget) begin
         run_over   = 1'b1;
         held_valid = 1'b0;
         return;
      end
      remaining = budget - words_done;
      if (held_valid) begin
         lng        = held_long && remaining >= 32'd2;
         held_valid = 1'b0;
      end else begin
         lng = draw_symbol(remaining);
      end
      // two shorts in a row merge, a long read ahead is held back
      if (!lng && remaining >= 32'd2) begin
         if (!draw_symbol(remaining - 32'd1)) begin
            lng = 1'b1;
         end else begin
            held_valid = 1'b1;
            held_long  = 1'b1;
         end
      end
      t.pos     = words_done;
      t.words   = lng ? atsg_pkg::WORDS_LONG : atsg_pkg::WORDS_SHORT;
      t.is_long = lng;
      t.last    = 32'(t.words) >= remaining;
      tiles_due.push_back(t);
      words_done = words_done + 32'(t.words);
      if (t.last) begin
         run_over   = 1'b1;
         held_valid = 1'b0;
      end
   endtask

   always @(posedge clock) begin : watch
      tile_rec_type want;
      if (reset) begin
         src_mode    = atsg_pkg::MODE_CUT_PROJECT;
         slope       = atsg_pkg::SLOPE_RESET;
         phase_start = atsg_pkg::PHASE_RESET;
         budget      = atsg_pkg::BUDGET_RESET;
         clear_run();
         tiles_due.delete();
      end else begin
         // a response leaving now belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (tiles_due.size() == 0) begin
               $display("%0t unexpected tile: expected none, got pos %0d words %0d",
                        $time, rsp_tile_pos, rsp_tile_words);
               mismatches++;
            end else begin
               want = tiles_due.pop_front();
               if (rsp_tile_pos !== want.pos) begin
                  $display("%0t tile_pos: expected %0d, got %0d",
                           $time, want.pos, rsp_tile_pos);
                  mismatches++;
               end
               if (rsp_tile_words !== want.words) begin
                  $display("%0t tile_words: expected %0d, got %0d",
                           $time, want.words, rsp_tile_words);
                  mismatches++;
               end
               if (rsp_is_long !== want.is_long) begin
                  $display("%0t is_long: expected %0b, got %0b",
                           $time, want.is_long, rsp_is_long);
                  mismatches++;
               end
               if (rsp_last_tile !== want.last) begin
                  $display("%0t last_tile: expected %0b, got %0b",
                           $time, want.last, rsp_last_tile);
                  mismatches++;
               end
            end
         end
         if (csr_write_en) begin
            case (atsg_pkg::csr_index_type'(csr_index))
               atsg_pkg::CSR_MODE:
                  src_mode = atsg_pkg::mode_type'(csr_write_data[1:0]);
               atsg_pkg::CSR_SLOPE:  slope       = csr_write_data;
               atsg_pkg::CSR_PHASE:  phase_start = csr_write_data;
               atsg_pkg::CSR_BUDGET: budget      = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) advance_tiling(req_restart);
      end
      tiles_owed = tiles_due.size();
   end

endmodule : tile_stream_checker

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the aperiodic tile sequence generator
// drives directed and random tile requests and restarts under random idling on
// both channels, reprograms the registers between runs, and takes the verdict
// from the checker that predicts every tile
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   // narrow symbol index so long runs reach the index wrap
   localparam int IDX_BITS    = 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEM_GOAL   = 1850;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic        req_restart    = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [31:0] rsp_tile_pos;
   logic [1:0]  rsp_tile_words;
   logic        rsp_is_long;
   logic        rsp_last_tile;
   logic        csr_write_en   = 1'b0;
   logic [1:0]  csr_index      = 2'd0;
   logic [31:0] csr_write_data = 32'd0;

   int          tiles_owed;
   int          mismatches;
   int          cycle_count    = 0;
   int          items_sent     = 0;
   int          stall_left     = 0;
   logic [31:0] words_budget   = atsg_pkg::BUDGET_RESET;
   bit          calm_phase     = 1'b0;

   aperiodic_tile_sequence_generator_unit #(
      .COUNT_BITS(IDX_BITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tile_pos   (rsp_tile_pos),
      .rsp_tile_words (rsp_tile_words),
      .rsp_is_long    (rsp_is_long),
      .rsp_last_tile  (rsp_last_tile),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   tile_stream_checker #(
      .COUNT_BITS(IDX_BITS)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tile_pos   (rsp_tile_pos),
      .rsp_tile_words (rsp_tile_words),
      .rsp_is_long    (rsp_is_long),
      .rsp_last_tile  (rsp_last_tile),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .tiles_owed     (tiles_owed),
      .mismatches     (mismatches)
   );

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("aperiodic_tile_sequence_generator_unit verification failed");
         $finish;
      end
   end

   // idle span: mostly short, now and then a long one
   function automatic int idle_span();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // response side back-pressure, switched off in calm phases
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm_phase && $urandom_range(0, 99) < 25) begin
         rsp_ready  <= 1'b0;
         stall_left <= idle_span() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one request; called at a rising edge, returns at one
   task automatic send_item(input logic restart);
      int gap;
      req_valid   <= 1'b1;
      req_restart <= restart;
      // ready is stable mid-cycle, the next rising edge takes the request
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      items_sent++;
      gap = (!calm_phase && $urandom_range(0, 99) < 40) ? idle_span() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every owed tile is out, then let the last request settle
   task automatic drain_all();
      req_valid <= 1'b0;
      do @(negedge clock); while (tiles_owed != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input atsg_pkg::csr_index_type idx,
                            input logic [31:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // write the selected registers back to back
   task automatic set_regs(input logic [3:0] sel, input atsg_pkg::mode_type m,
                           input logic [31:0] slope, input logic [31:0] phase,
                           input logic [31:0] budget);
      if (sel[atsg_pkg::CSR_MODE])   write_reg(atsg_pkg::CSR_MODE, {30'd0, m});
      if (sel[atsg_pkg::CSR_SLOPE])  write_reg(atsg_pkg::CSR_SLOPE, slope);
      if (sel[atsg_pkg::CSR_PHASE])  write_reg(atsg_pkg::CSR_PHASE, phase);
      if (sel[atsg_pkg::CSR_BUDGET]) write_reg(atsg_pkg::CSR_BUDGET, budget);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (sel[atsg_pkg::CSR_BUDGET]) words_budget = budget;
   endtask

   initial begin : stimulus
      int                 phase_no;
      int                 n;
      logic [3:0]         sel;
      atsg_pkg::mode_type m;
      logic [31:0]        slope;
      logic [31:0]        phase;
      logic [31:0]        budget;
      bit                 fresh;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // zero budget out of reset: request gives nothing
      send_item(1'b0);
      drain_all();

      // reset mode and slope, short run and one request past its end
      set_regs(4'b1000, atsg_pkg::MODE_CUT_PROJECT, 32'd0, 32'd0, 32'd6);
      send_item(1'b1);
      repeat (5) send_item(1'b0);
      drain_all();

      set_regs(4'b1001, atsg_pkg::MODE_THUE_MORSE, 32'd0, 32'd0, 32'd4);
      send_item(1'b1);
      repeat (3) send_item(1'b0);
      drain_all();

      set_regs(4'b0001, atsg_pkg::MODE_RUDIN_SHAPIRO, 32'd0, 32'd0, 32'd0);
      send_item(1'b1);
      repeat (3) send_item(1'b0);
      drain_all();

      set_regs(4'b1101, atsg_pkg::MODE_PERIOD_DOUBLING, 32'd0, 32'hFFFF_FFFF, 32'd3);
      send_item(1'b1);
      repeat (3) send_item(1'b0);
      drain_all();

      // short then long: the long is held, then the budget drops to one word
      // left so the held long comes out short and ends the run
      set_regs(4'b1111, atsg_pkg::MODE_CUT_PROJECT, 32'hFFFF_FFFF, 32'd0, 32'd10);
      send_item(1'b1);
      send_item(1'b0);
      drain_all();
      set_regs(4'b1000, atsg_pkg::MODE_CUT_PROJECT, 32'd0, 32'd0, 32'd2);
      send_item(1'b0);
      send_item(1'b0);
      drain_all();

      // ---- random runs ----
      phase_no = 0;
      while (items_sent < ITEM_GOAL) begin
         calm_phase = ($urandom_range(0, 4) == 0);
         m = atsg_pkg::mode_type'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0:       slope = 32'd0;
            1:       slope = 32'hFFFF_FFFF;
            2:       slope = atsg_pkg::SLOPE_RESET;
            default: slope = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0:       phase = 32'd0;
            1:       phase = 32'hFFFF_FFFF;
            default: phase = $urandom;
         endcase
         case ($urandom_range(0, 9))
            0:       budget = $urandom_range(0, 2);
            1:       budget = $urandom;
            default: budget = $urandom_range(3, 40);
         endcase
         sel   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'b1111;
         fresh = ($urandom_range(0, 5) != 0);
         // two long runs, so the symbol index wraps
         if (phase_no == 6 || phase_no == 30) begin
            calm_phase = 1'b1;
            budget     = $urandom_range(450, 700);
            sel        = 4'b1111;
            fresh      = 1'b1;
         end
         set_regs(sel, m, slope, phase, budget);

         // mostly a clean run; skipping the restart keeps going mid-run
         if (words_budget > 32'd1000) n = $urandom_range(20, 80);
         else n = words_budget / 2 + $urandom_range(0, words_budget / 2 + 2);
         if (fresh) send_item(1'b1);
         repeat (n) send_item($urandom_range(0, 49) == 0);

         // registers only change with nothing in flight
         drain_all();
         phase_no++;
      end

      calm_phase = 1'b0;
      drain_all();
      repeat (10) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && tiles_owed == 0) begin
         $display("aperiodic_tile_sequence_generator_unit verification clean");
      end else begin
         $display("aperiodic_tile_sequence_generator_unit verification failed");
      end
      $finish;
   end

endmodule : tb_top

`default_nettype wire

// File: aperiodic_tile_sequence_generator_unit.f
rtl/atsg_pkg.sv
rtl/aperiodic_tile_sequence_generator_unit.sv
bench/tile_stream_checker.sv
bench/tb_top.sv
